### src/radial_edge_length_interp_unit_assert.svh
// Assertion macros used by the radial edge length interpolation top level.
`ifndef RADIAL_EDGE_LENGTH_INTERP_UNIT_ASSERT_SVH
`define RADIAL_EDGE_LENGTH_INTERP_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RELINT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RELINT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/relint_pkg.sv
// Package with types and constants of the radial edge length interpolation unit.
`default_nettype none
package relint_pkg;

    localparam int MAX_RINGS_DEF = 4;

    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_RING_COUNT = 3'd2;
    localparam logic [2:0] REG_RING_RADII = 3'd3;
    localparam logic [2:0] REG_RING_EDGES = 3'd4;

    typedef struct packed {
        logic [2:0]  hit;
        logic [15:0] bg;
        logic [15:0] ea;
        logic [15:0] mag;
        logic        neg;
        logic [15:0] den;
        logic [15:0] ra;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]  hit;
        logic [15:0] bg;
        logic [15:0] ea;
        logic [15:0] mag;
        logic        neg;
    } t_dv_side;

    localparam int SQRT_SIDE_W = $bits(t_sq_side);
    localparam int DIV_SIDE_W  = $bits(t_dv_side);

endpackage
`default_nettype wire

### src/relint_if.sv
// Valid/ready channel interfaces for query points and results.
`default_nettype none
interface relint_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [15:0] background_edge;

    modport source (output valid, point_x, point_y, background_edge, input ready);
    modport sink   (input valid, point_x, point_y, background_edge, output ready);
endinterface

interface relint_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_edge;
    logic [2:0]  ring_hit;

    modport source (output valid, max_edge, ring_hit, input ready);
    modport sink   (input valid, max_edge, ring_hit, output ready);
endinterface
`default_nettype wire

### src/relint_sqrt.sv
// Pipelined integer square root of a 32-bit value, two result bits per stage.
`default_nettype none
module relint_sqrt
    import relint_pkg::*;
#(
    parameter int SIDE_W = SQRT_SIDE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_radicand,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [15:0]            o_root,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int STEPS  = 2;
    localparam int STAGES = 16 / STEPS;

    logic [STAGES-1:0] r_valid;
    logic [16:0]       r_rem  [STAGES];
    logic [15:0]       r_root [STAGES];
    logic [31:0]       r_v    [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic [16:0]       n_rem  [STAGES];
    logic [15:0]       n_root [STAGES];
    logic [31:0]       n_v    [STAGES];

    always_comb begin
        logic [16:0] rem;
        logic [15:0] root;
        logic [31:0] v;
        logic [18:0] t;
        logic [18:0] trial;
        logic [18:0] diff;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                rem  = '0;
                root = '0;
                v    = i_radicand;
            end else begin
                rem  = r_rem[s-1];
                root = r_root[s-1];
                v    = r_v[s-1];
            end
            for (int k = 0; k < STEPS; k++) begin
                t     = {rem, v[31:30]};
                trial = {1'b0, root, 2'b01};
                diff  = t - trial;
                if (t >= trial) begin
                    rem  = diff[16:0];
                    root = {root[14:0], 1'b1};
                end else begin
                    rem  = t[16:0];
                    root = {root[14:0], 1'b0};
                end
                v = {v[29:0], 2'b00};
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_v[s]    = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_v[s]    <= n_v[s];
                r_side[s] <= (s == 0) ? i_side : r_side[s-1];
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_root  = r_root[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
`default_nettype wire

### src/relint_div.sv
// Pipelined 32 by 16 bit unsigned divider with a 16-bit quotient, two bits per stage.
`default_nettype none
module relint_div
    import relint_pkg::*;
#(
    parameter int SIDE_W = DIV_SIDE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [15:0]       i_divisor,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [15:0]            o_quot,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int STEPS  = 2;
    localparam int STAGES = 16 / STEPS;

    logic [STAGES-1:0] r_valid;
    logic [15:0]       r_rem  [STAGES];
    logic [15:0]       r_dvd  [STAGES];
    logic [15:0]       r_den  [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic [15:0]       n_rem  [STAGES];
    logic [15:0]       n_dvd  [STAGES];

    always_comb begin
        logic [15:0] rem;
        logic [15:0] dvd;
        logic [15:0] den;
        logic [16:0] t;
        logic [16:0] diff;
        logic        qbit;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                rem = i_dividend[31:16];
                dvd = i_dividend[15:0];
                den = i_divisor;
            end else begin
                rem = r_rem[s-1];
                dvd = r_dvd[s-1];
                den = r_den[s-1];
            end
            for (int k = 0; k < STEPS; k++) begin
                t    = {rem, dvd[15]};
                diff = t - {1'b0, den};
                qbit = (t >= {1'b0, den});
                rem  = qbit ? diff[15:0] : t[15:0];
                dvd  = {dvd[14:0], qbit};
            end
            n_rem[s] = rem;
            n_dvd[s] = dvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_dvd[s]  <= n_dvd[s];
                r_den[s]  <= (s == 0) ? i_divisor : r_den[s-1];
                r_side[s] <= (s == 0) ? i_side : r_side[s-1];
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_quot  = r_dvd[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
`default_nettype wire

### src/radial_edge_length_interp_unit.sv
// Top level of the radial edge length interpolation unit.
// Throughput is one item per cycle unless the output stalls; the square root and
// divider pipelines set the depth. The whole pipeline holds while a result waits
// on the output register. Synchronous active-low reset clears the valid bits and
// the configuration registers, but sets the ring count to 1.
`default_nettype none
`include "radial_edge_length_interp_unit_assert.svh"
module radial_edge_length_interp_unit
    import relint_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   psel,
    input  wire logic   penable,
    input  wire logic   pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    relint_in_if.sink   i_in,
    relint_out_if.source o_out
);

    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [2:0]  r_ring_count;
    logic [63:0] r_radii;
    logic [63:0] r_edges;
    logic [31:0] r_rsq [MAX_RINGS];
    logic        w_cfg_wr;
    logic [2:0]  w_n;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_ring_count <= 3'd1;
            r_radii      <= '0;
            r_edges      <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                REG_CENTER_X:   r_center_x   <= pwdata[15:0];
                REG_CENTER_Y:   r_center_y   <= pwdata[15:0];
                REG_RING_COUNT: r_ring_count <= pwdata[2:0];
                REG_RING_RADII: r_radii      <= pwdata;
                REG_RING_EDGES: r_edges      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_CENTER_X:   prdata = {48'd0, r_center_x};
            REG_CENTER_Y:   prdata = {48'd0, r_center_y};
            REG_RING_COUNT: prdata = {61'd0, r_ring_count};
            REG_RING_RADII: prdata = r_radii;
            REG_RING_EDGES: prdata = r_edges;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RINGS; k++) begin
            r_rsq[k] <= r_radii[16*k +: 16] * r_radii[16*k +: 16];
        end
    end

    always_comb begin
        if (r_ring_count == 3'd0) begin
            w_n = 3'd1;
        end else if (r_ring_count > 3'(MAX_RINGS)) begin
            w_n = 3'(MAX_RINGS);
        end else begin
            w_n = r_ring_count;
        end
    end

    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // Stage 1: absolute coordinate differences.
    logic        r1_valid;
    logic [15:0] r1_ax;
    logic [15:0] r1_ay;
    logic [15:0] r1_bg;
    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [16:0] w_ax;
    logic [16:0] w_ay;

    assign w_dx = {i_in.point_x[15], i_in.point_x} - {r_center_x[15], r_center_x};
    assign w_dy = {i_in.point_y[15], i_in.point_y} - {r_center_y[15], r_center_y};
    assign w_ax = w_dx[16] ? (17'd0 - w_dx) : w_dx;
    assign w_ay = w_dy[16] ? (17'd0 - w_dy) : w_dy;

    // Stage 2: squares. Stage 3: squared distance.
    logic        r2_valid;
    logic [31:0] r2_sqx;
    logic [31:0] r2_sqy;
    logic [15:0] r2_bg;
    logic        r3_valid;
    logic [32:0] r3_d2;
    logic [15:0] r3_bg;

    // Stage 4: ring search and operand selection.
    logic        r4_valid;
    logic [31:0] r4_rad;
    t_sq_side    r4_side;
    t_sq_side    w_sel;
    logic [MAX_RINGS-1:0] w_in_ring;

    always_comb begin
        logic        stop;
        logic [15:0] ra;
        logic [15:0] rb;
        logic [15:0] ea;
        logic [15:0] eb;
        logic [16:0] de;
        for (int k = 0; k < MAX_RINGS; k++) begin
            w_in_ring[k] = (r3_d2 <= {1'b0, r_rsq[k]});
        end
        w_sel.hit = w_n;
        stop = 1'b0;
        for (int i = MAX_RINGS - 1; i >= 1; i--) begin
            if ((3'(i) < w_n) && !stop) begin
                if (w_in_ring[i]) begin
                    w_sel.hit = 3'(i);
                end else begin
                    stop = 1'b1;
                end
            end
        end
        if (w_in_ring[0]) begin
            w_sel.hit = 3'd0;
        end
        ra = '0;
        rb = '0;
        ea = '0;
        eb = '0;
        for (int k = 1; k < MAX_RINGS; k++) begin
            if (w_sel.hit == 3'(k)) begin
                ra = r_radii[16*(k-1) +: 16];
                rb = r_radii[16*k +: 16];
                ea = r_edges[16*(k-1) +: 16];
                eb = r_edges[16*k +: 16];
            end
        end
        de        = {1'b0, eb} - {1'b0, ea};
        w_sel.bg  = r3_bg;
        w_sel.ea  = ea;
        w_sel.neg = de[16];
        w_sel.mag = de[16] ? 16'(17'd0 - de) : de[15:0];
        w_sel.den = rb - ra;
        w_sel.ra  = ra;
        if (w_sel.hit == 3'd0) begin
            w_sel.ea  = r_edges[15:0];
            w_sel.mag = '0;
            w_sel.neg = 1'b0;
            w_sel.den = 16'd1;
            w_sel.ra  = '0;
        end else if (w_sel.hit == w_n) begin
            w_sel.ea  = r3_bg;
            w_sel.mag = '0;
            w_sel.neg = 1'b0;
            w_sel.den = 16'd1;
            w_sel.ra  = '0;
        end
    end

    logic                   w_sq_valid;
    logic [15:0]            w_sq_root;
    logic [SQRT_SIDE_W-1:0] w_sq_side_bits;
    t_sq_side               w_sq_side;

    relint_sqrt #(
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r4_valid),
        .i_radicand (r4_rad),
        .i_side     (r4_side),
        .o_valid    (w_sq_valid),
        .o_root     (w_sq_root),
        .o_side     (w_sq_side_bits)
    );

    assign w_sq_side = t_sq_side'(w_sq_side_bits);

    // Stage M1: offset from inner radius. Stage M2: numerator product.
    logic        r5_valid;
    logic [15:0] r5_a;
    logic [15:0] r5_den;
    t_dv_side    r5_side;
    logic        r6_valid;
    logic [31:0] r6_prod;
    logic [15:0] r6_den;
    t_dv_side    r6_side;

    logic                  w_div_valid;
    logic [15:0]           w_div_q;
    logic [DIV_SIDE_W-1:0] w_div_side_bits;
    t_dv_side              w_div_side;

    relint_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r6_valid),
        .i_dividend (r6_prod),
        .i_divisor  (r6_den),
        .i_side     (r6_side),
        .o_valid    (w_div_valid),
        .o_quot     (w_div_q),
        .o_side     (w_div_side_bits)
    );

    assign w_div_side = t_dv_side'(w_div_side_bits);

    logic [16:0] w_val;
    logic [15:0] w_res;

    assign w_val = w_div_side.neg ? ({1'b0, w_div_side.ea} - {1'b0, w_div_q})
                                  : ({1'b0, w_div_side.ea} + {1'b0, w_div_q});
    assign w_res = (w_div_side.bg < w_val[15:0]) ? w_div_side.bg : w_val[15:0];

    logic [15:0] r_out_edge;
    logic [2:0]  r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= i_in.valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= w_sq_valid;
            r6_valid    <= r5_valid;
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax   <= w_ax[15:0];
            r1_ay   <= w_ay[15:0];
            r1_bg   <= i_in.background_edge;
            r2_sqx  <= r1_ax * r1_ax;
            r2_sqy  <= r1_ay * r1_ay;
            r2_bg   <= r1_bg;
            r3_d2   <= {1'b0, r2_sqx} + {1'b0, r2_sqy};
            r3_bg   <= r2_bg;
            r4_rad  <= r3_d2[32] ? 32'hFFFF_FFFF : r3_d2[31:0];
            r4_side <= w_sel;
            r5_a    <= w_sq_root - w_sq_side.ra;
            r5_den  <= w_sq_side.den;
            r5_side <= '{hit: w_sq_side.hit, bg: w_sq_side.bg, ea: w_sq_side.ea,
                         mag: w_sq_side.mag, neg: w_sq_side.neg};
            r6_prod <= r5_a * r5_side.mag;
            r6_den  <= r5_den;
            r6_side <= r5_side;
            r_out_edge <= w_res;
            r_out_hit  <= w_div_side.hit;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.max_edge = r_out_edge;
    assign o_out.ring_hit = r_out_hit;

    `RELINT_ASSERT_SAME(a_quot_bound, w_div_valid, w_div_q <= w_div_side.mag,
        "interpolation step exceeds the edge difference")
    `RELINT_ASSERT_NEXT(a_result_le_bg, w_en && w_div_valid,
        o_out.valid && (o_out.max_edge <= $past(w_div_side.bg)),
        "result exceeds the background edge length")

endmodule
`default_nettype wire
